/* src/shfnr_pkg.sv */
`default_nettype none

package shfnr_pkg;

	localparam int BYTE_W      = 8;
	localparam int FRAME_NUM_W = 16;
	localparam int CFG_W       = 4;

	localparam int DEF_MAX_GOLOMB_ZEROS   = 31;
	localparam int DEF_FRAME_NUM_MAX_BITS = 16;

	// Field width is register value plus this offset
	localparam int FIELD_W_OFFSET = 4;

	localparam logic [BYTE_W-1:0] EMU_PREVENT_BYTE = 8'h03;
	localparam logic [1:0]        ZERO_RUN_CAP     = 2'd2;

endpackage

`default_nettype wire

/* src/shfnr_if.sv */
`default_nettype none

interface shfnr_in_if import shfnr_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [BYTE_W-1:0]      in_byte;
	logic                   first_of_nal;
	logic                   last_of_nal;
	logic [FRAME_NUM_W-1:0] new_frame_num;

	modport source (output valid, in_byte, first_of_nal, last_of_nal, new_frame_num,
		input ready);
	modport sink (input valid, in_byte, first_of_nal, last_of_nal, new_frame_num,
		output ready);
endinterface

interface shfnr_out_if import shfnr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic              out_last;
	logic              header_error;

	modport source (output valid, out_byte, out_last, header_error, input ready);
	modport sink (input valid, out_byte, out_last, header_error, output ready);
endinterface

interface shfnr_cfg_if import shfnr_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CFG_W-1:0] frame_num_bits_minus4;

	modport source (output valid, frame_num_bits_minus4, input ready);
	modport sink (input valid, frame_num_bits_minus4, output ready);
endinterface

`default_nettype wire

/* src/slice_header_frame_num_rewriter.sv */
`default_nettype none

// H.264 slice header frame number rewriter.
// din : one escaped NAL byte per beat. first_of_nal marks the NAL header byte
//       and samples new_frame_num; last_of_nal marks the final byte.
// dout: rewritten, re-escaped bytes. out_last on the final beat of the NAL;
//       header_error on that beat if the frame number field was not fully rewritten.
// cfg : frame_num_bits_minus4, always ready; write only while idle.
// Flow: din beat -> input register (_s1) -> one pass of unescape, 8-bit
//       Golomb skip / field overwrite, re-escape -> 4-entry result queue.
// Throughput: one input byte per cycle while the queue has room. A byte may
//       yield two beats (an inserted 03 plus the byte) and a dropped 03 yields
//       none; the queue drains one beat per cycle while dout.ready is high, so
//       din.ready drops only while the queue holds more than two beats.
// Stall: when dout.ready is low the queue fills and then holds din off; no
//       beat is lost or repeated.
// Reset: arst_n clears the parser to "expecting header byte", the zero runs,
//       the queue and the register (width 4).
module slice_header_frame_num_rewriter
	import shfnr_pkg::*;
#(
	parameter int MAX_GOLOMB_ZEROS   = DEF_MAX_GOLOMB_ZEROS,
	parameter int FRAME_NUM_MAX_BITS = DEF_FRAME_NUM_MAX_BITS
) (
	input  wire         clk,
	input  wire         arst_n,
	shfnr_cfg_if.sink   cfg,
	shfnr_in_if.sink    din,
	shfnr_out_if.source dout
);

	localparam int ZC_W  = $clog2(MAX_GOLOMB_ZEROS + 1);
	localparam int FB_W  = $clog2(FRAME_NUM_MAX_BITS + 1);
	localparam int FI_W  = $clog2(FRAME_NUM_MAX_BITS);
	localparam int DEPTH = 4;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef enum logic [2:0] {
		PH_HEAD,
		PH_CODE1,
		PH_CODE2,
		PH_CODE3,
		PH_FIELD,
		PH_COPY,
		PH_ABORT
	} phase_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              last;
		logic              err;
	} beat_t;

	// config
	logic [CFG_W-1:0] fnb_minus4_q;

	// input register
	logic                   vld_s1;
	logic [BYTE_W-1:0]      byte_s1;
	logic                   first_s1;
	logic                   last_s1;
	logic [FRAME_NUM_W-1:0] fnum_s1;

	// parser state
	phase_t                        phase_q;
	logic [1:0]                    in_run_q;
	logic [1:0]                    out_run_q;
	logic [ZC_W-1:0]               zc_q;
	logic [ZC_W-1:0]               sl_q;
	logic [FB_W-1:0]               fbl_q;
	logic [FRAME_NUM_MAX_BITS-1:0] held_q;

	// result queue
	beat_t            mem_q [DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [CNT_W-1:0] cnt_q;

	logic s1_fire;
	logic pop;

	// bit-loop results
	phase_t            lp_phase;
	logic [ZC_W-1:0]   lp_zc;
	logic [ZC_W-1:0]   lp_sl;
	logic [FB_W-1:0]   lp_fbl;
	logic [BYTE_W-1:0] ob;
	logic [FB_W-1:0]   field_w;
	logic [5:0]        fw_raw;

	// per-byte decision
	logic [1:0]  push_cnt;
	beat_t       ent0;
	beat_t       ent1;
	phase_t      nxt_phase;
	logic [1:0]  nxt_in_run;
	logic [1:0]  nxt_out_run;
	logic [ZC_W-1:0] nxt_zc;
	logic [ZC_W-1:0] nxt_sl;
	logic [FB_W-1:0] nxt_fbl;
	logic        load_held;
	logic        emu;

	assign cfg.ready = 1'b1;

	assign s1_fire  = vld_s1 && (cnt_q <= CNT_W'(DEPTH - 2));
	assign din.ready = !vld_s1 || s1_fire;

	assign pop           = (cnt_q != '0) && dout.ready;
	assign dout.valid    = (cnt_q != '0);
	assign dout.out_byte = mem_q[rptr_q].data;
	assign dout.out_last = mem_q[rptr_q].last;
	assign dout.header_error = mem_q[rptr_q].err;

	// frame number field width, saturated
	always_comb begin
		fw_raw = {2'b00, fnb_minus4_q} + 6'(FIELD_W_OFFSET);
		if (fw_raw > 6'(FRAME_NUM_MAX_BITS))
			field_w = FB_W'(FRAME_NUM_MAX_BITS);
		else
			field_w = FB_W'(fw_raw);
	end

	// Eight MSB-first bit steps of the Golomb skipper / field overwriter
	always_comb begin
		logic bit_in;
		logic obit;
		logic done;
		lp_phase = phase_q;
		lp_zc    = zc_q;
		lp_sl    = sl_q;
		lp_fbl   = fbl_q;
		ob       = '0;
		for (int i = BYTE_W - 1; i >= 0; i--) begin
			bit_in = byte_s1[i];
			obit   = bit_in;
			done   = 1'b0;
			if (lp_phase == PH_CODE1 || lp_phase == PH_CODE2 || lp_phase == PH_CODE3) begin
				if (lp_sl != '0) begin
					lp_sl = lp_sl - 1'b1;
					if (lp_sl == '0)
						done = 1'b1;
				end else if (!bit_in) begin
					if (lp_zc >= ZC_W'(MAX_GOLOMB_ZEROS))
						lp_phase = PH_ABORT;
					else
						lp_zc = lp_zc + 1'b1;
				end else if (lp_zc == '0) begin
					done = 1'b1;
				end else begin
					lp_sl = lp_zc;
				end
				if (done) begin
					lp_zc = '0;
					lp_sl = '0;
					case (lp_phase)
						PH_CODE1: lp_phase = PH_CODE2;
						PH_CODE2: lp_phase = PH_CODE3;
						PH_CODE3: begin
							lp_phase = PH_FIELD;
							lp_fbl   = field_w;
						end
						default: lp_phase = lp_phase;
					endcase
				end
			end else if (lp_phase == PH_FIELD) begin
				if (lp_fbl == '0) begin
					lp_phase = PH_COPY;
				end else begin
					lp_fbl = lp_fbl - 1'b1;
					obit   = held_q[lp_fbl[FI_W-1:0]];
					if (lp_fbl == '0)
						lp_phase = PH_COPY;
				end
			end
			ob[i] = obit;
		end
	end

	// unescape / re-escape and beat generation
	always_comb begin
		push_cnt    = 2'd0;
		ent0        = '{data: byte_s1, last: 1'b0, err: 1'b0};
		ent1        = '{data: ob, last: 1'b0, err: 1'b0};
		nxt_phase   = phase_q;
		nxt_in_run  = in_run_q;
		nxt_out_run = out_run_q;
		nxt_zc      = zc_q;
		nxt_sl      = sl_q;
		nxt_fbl     = fbl_q;
		load_held   = 1'b0;
		emu         = 1'b0;
		if (first_s1 || phase_q == PH_HEAD) begin
			// header byte: restart the parse
			load_held   = 1'b1;
			push_cnt    = 2'd1;
			ent0        = '{data: byte_s1, last: last_s1, err: last_s1};
			nxt_phase   = last_s1 ? PH_HEAD : PH_CODE1;
			nxt_in_run  = '0;
			nxt_out_run = '0;
			nxt_zc      = '0;
			nxt_sl      = '0;
			nxt_fbl     = '0;
		end else if (in_run_q == ZERO_RUN_CAP && byte_s1 == EMU_PREVENT_BYTE) begin
			// dropped escape; re-emitted only when it closes the NAL
			nxt_in_run = '0;
			if (last_s1) begin
				push_cnt    = 2'd1;
				ent0        = '{data: EMU_PREVENT_BYTE, last: 1'b1,
					err: (phase_q != PH_COPY)};
				nxt_phase   = PH_HEAD;
				nxt_out_run = '0;
			end
		end else begin
			if (byte_s1 == '0)
				nxt_in_run = (in_run_q < ZERO_RUN_CAP) ? in_run_q + 1'b1 : in_run_q;
			else
				nxt_in_run = '0;
			nxt_phase = lp_phase;
			nxt_zc    = lp_zc;
			nxt_sl    = lp_sl;
			nxt_fbl   = lp_fbl;
			emu = (out_run_q == ZERO_RUN_CAP) && (ob <= BYTE_W'(EMU_PREVENT_BYTE));
			if (emu) begin
				push_cnt = 2'd2;
				ent0     = '{data: EMU_PREVENT_BYTE, last: 1'b0, err: 1'b0};
				ent1     = '{data: ob, last: last_s1,
					err: last_s1 && (lp_phase != PH_COPY)};
			end else begin
				push_cnt = 2'd1;
				ent0     = '{data: ob, last: last_s1,
					err: last_s1 && (lp_phase != PH_COPY)};
			end
			if (ob != '0)
				nxt_out_run = '0;
			else if (emu)
				nxt_out_run = 2'd1;
			else
				nxt_out_run = (out_run_q < ZERO_RUN_CAP) ? out_run_q + 1'b1 : out_run_q;
			if (last_s1) begin
				nxt_phase   = PH_HEAD;
				nxt_in_run  = '0;
				nxt_out_run = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fnb_minus4_q <= '0;
			vld_s1       <= 1'b0;
			phase_q      <= PH_HEAD;
			in_run_q     <= '0;
			out_run_q    <= '0;
			zc_q         <= '0;
			sl_q         <= '0;
			fbl_q        <= '0;
			held_q       <= '0;
			wptr_q       <= '0;
			rptr_q       <= '0;
			cnt_q        <= '0;
		end else begin
			if (cfg.valid)
				fnb_minus4_q <= cfg.frame_num_bits_minus4;

			if (din.ready)
				vld_s1 <= din.valid;

			if (s1_fire) begin
				phase_q   <= nxt_phase;
				in_run_q  <= nxt_in_run;
				out_run_q <= nxt_out_run;
				zc_q      <= nxt_zc;
				sl_q      <= nxt_sl;
				fbl_q     <= nxt_fbl;
				if (load_held)
					held_q <= fnum_s1[FRAME_NUM_MAX_BITS-1:0];
				wptr_q <= wptr_q + PTR_W'(push_cnt);
			end

			if (pop)
				rptr_q <= rptr_q + 1'b1;

			cnt_q <= cnt_q + (s1_fire ? CNT_W'(push_cnt) : '0) - CNT_W'(pop);
		end
	end

	// payload registers: no reset
	always_ff @(posedge clk) begin
		if (din.valid && din.ready) begin
			byte_s1  <= din.in_byte;
			first_s1 <= din.first_of_nal;
			last_s1  <= din.last_of_nal;
			fnum_s1  <= din.new_frame_num;
		end
		if (s1_fire && push_cnt != 2'd0)
			mem_q[wptr_q] <= ent0;
		if (s1_fire && push_cnt == 2'd2)
			mem_q[wptr_q + 1'b1] <= ent1;
	end

`ifndef SYNTHESIS
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("result queue overflow");

	a_last_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && last_s1 |=> phase_q == PH_HEAD && in_run_q == '0 && out_run_q == '0)
		else $error("parser not restarted after last byte");

	a_err_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid && dout.header_error |-> dout.out_last)
		else $error("header_error outside final beat");

	a_runs_capped: assert property (@(posedge clk) disable iff (!arst_n)
		in_run_q <= ZERO_RUN_CAP && out_run_q <= ZERO_RUN_CAP)
		else $error("zero run counter beyond cap");

	a_no_loss_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !s1_fire |=> vld_s1 && $stable(byte_s1))
		else $error("input register dropped a byte");
`endif

endmodule

`default_nettype wire

/* test/tb_slice_header_frame_num_rewriter.sv */
`default_nettype none

module tb_slice_header_frame_num_rewriter import shfnr_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	// Cycles with no beat on any channel before the run is declared hung.
	// The longest legal quiet stretch is the forced receiver hold below.
	localparam int QUIET_LIMIT   = 3000;
	localparam int LONG_HOLD     = 300;
	// A dropped 03 gives no output beat; give the pipe this long to empty
	// before touching the register or ending the run.
	localparam int SETTLE_CYCLES = 4;
	localparam int MAX_REPORTS   = 60;

	// Parser position inside the slice header, in bitstream order.
	typedef enum logic [2:0] {
		STG_HEADER,
		STG_FIRST_MB,
		STG_SLICE_TYPE,
		STG_PPS_ID,
		STG_FRAME_NUM,
		STG_COPY,
		STG_ABORT
	} parse_stage_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              last;
		logic              err;
	} nal_beat_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	always #1 clk = ~clk;

	shfnr_in_if  din_if ();
	shfnr_out_if dout_if ();
	shfnr_cfg_if cfg_if ();

	slice_header_frame_num_rewriter u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_if),
		.din    (din_if),
		.dout   (dout_if)
	);

	// ---------------------------------------------------------------
	// Predictor state: own copy of the register and of the parser.
	// ---------------------------------------------------------------
	logic [CFG_W-1:0]       fn_bits_m4  = '0;
	parse_stage_t           stage       = STG_HEADER;
	logic [1:0]             in_zeros    = '0;
	logic [1:0]             out_zeros   = '0;
	int unsigned            prefix_zeros = 0;
	int unsigned            suffix_left = 0;
	int unsigned            field_left  = 0;
	logic [FRAME_NUM_W-1:0] held_fnum   = '0;

	nal_beat_t   rewritten_q[$];   // beats still owed by the block
	int unsigned fail_count   = 0;
	int unsigned items_sent   = 0;
	int unsigned quiet_cycles = 0;

	// Idling knobs; the _pct ones are percent of cycles.
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_request = 0;
	int hold_left = 0;

	function automatic int field_width();
		int w;
		w = int'(fn_bits_m4) + FIELD_W_OFFSET;
		if (w > DEF_FRAME_NUM_MAX_BITS) w = DEF_FRAME_NUM_MAX_BITS;
		return w;
	endfunction

	// One Exp-Golomb code finished: move on, arm the field counter on entry.
	function automatic void end_code();
		prefix_zeros = 0;
		suffix_left  = 0;
		stage        = parse_stage_t'(stage + 1);
		if (stage == STG_FRAME_NUM) field_left = field_width();
	endfunction

	// Walk one unescaped payload bit through the header parser; returns
	// the bit to emit (the new frame number bit while inside the field).
	function automatic logic steer_bit(input logic b);
		logic res;
		res = b;
		case (stage)
			STG_FIRST_MB, STG_SLICE_TYPE, STG_PPS_ID: begin
				if (suffix_left != 0) begin
					suffix_left--;
					if (suffix_left == 0) end_code();
				end else if (!b) begin
					// prefix too long: give up, rest of NAL copied as is
					if (prefix_zeros >= DEF_MAX_GOLOMB_ZEROS) stage = STG_ABORT;
					else prefix_zeros++;
				end else if (prefix_zeros == 0) begin
					end_code();
				end else begin
					suffix_left = prefix_zeros;
				end
			end
			STG_FRAME_NUM: begin
				if (field_left == 0) begin
					stage = STG_COPY;
				end else begin
					field_left--;
					res = held_fnum[field_left];
					if (field_left == 0) stage = STG_COPY;
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	// Expected output beats for one accepted input beat.
	task automatic predict_rewrite(input logic [BYTE_W-1:0] b, input logic first,
			input logic last, input logic [FRAME_NUM_W-1:0] fnum);
		nal_beat_t   beats[$];
		logic [7:0]  ob;
		if (first || stage == STG_HEADER) begin
			// header byte (marked or not) restarts everything, passes as is
			held_fnum    = fnum;
			stage        = STG_FIRST_MB;
			in_zeros     = '0;
			out_zeros    = '0;
			prefix_zeros = 0;
			suffix_left  = 0;
			field_left   = 0;
			beats.push_back('{data: b, last: 1'b0, err: 1'b0});
		end else if (in_zeros == ZERO_RUN_CAP && b == EMU_PREVENT_BYTE) begin
			// emulation prevention byte: dropped, unless it closes the NAL
			in_zeros = '0;
			if (last) beats.push_back('{data: EMU_PREVENT_BYTE, last: 1'b0, err: 1'b0});
		end else begin
			if (b == '0) begin
				if (in_zeros < ZERO_RUN_CAP) in_zeros++;
			end else begin
				in_zeros = '0;
			end
			for (int i = 7; i >= 0; i--) ob[i] = steer_bit(b[i]);
			// re-escape: 03 goes in front of any byte <= 3 after 00 00
			if (out_zeros == ZERO_RUN_CAP && ob <= EMU_PREVENT_BYTE) begin
				beats.push_back('{data: EMU_PREVENT_BYTE, last: 1'b0, err: 1'b0});
				out_zeros = '0;
			end
			beats.push_back('{data: ob, last: 1'b0, err: 1'b0});
			if (ob == '0) begin
				if (out_zeros < ZERO_RUN_CAP) out_zeros++;
			end else begin
				out_zeros = '0;
			end
		end
		if (last) begin
			beats[beats.size()-1].last = 1'b1;
			beats[beats.size()-1].err  = (stage != STG_COPY);
			stage     = STG_HEADER;
			in_zeros  = '0;
			out_zeros = '0;
		end
		foreach (beats[i]) rewritten_q.push_back(beats[i]);
	endtask

	task automatic report_mismatch(input string msg);
		fail_count++;
		if (fail_count <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
	endtask

	task automatic check_rewritten_beat();
		nal_beat_t want;
		if (rewritten_q.size() == 0) begin
			report_mismatch($sformatf("unexpected beat %02h last %0b err %0b",
				dout_if.out_byte, dout_if.out_last, dout_if.header_error));
			return;
		end
		want = rewritten_q.pop_front();
		if (dout_if.out_byte !== want.data)
			report_mismatch($sformatf("out_byte got %02h want %02h",
				dout_if.out_byte, want.data));
		if (dout_if.out_last !== want.last)
			report_mismatch($sformatf("out_last got %0b want %0b (byte %02h)",
				dout_if.out_last, want.last, want.data));
		if (dout_if.header_error !== want.err)
			report_mismatch($sformatf("header_error got %0b want %0b (byte %02h)",
				dout_if.header_error, want.err, want.data));
	endtask

	// ---------------------------------------------------------------
	// Monitor: everything sampled at the rising edge, pre-update values.
	// Input beats feed the predictor, output beats get checked.
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (din_if.valid && din_if.ready)
				predict_rewrite(din_if.in_byte, din_if.first_of_nal,
					din_if.last_of_nal, din_if.new_frame_num);
			if (dout_if.valid && dout_if.ready) check_rewritten_beat();
		end
	end

	// Hang detection: any beat on any channel resets the count.
	always @(posedge clk) begin
		if ((din_if.valid && din_if.ready) || (dout_if.valid && dout_if.ready) ||
				(cfg_if.valid && cfg_if.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("Regression FAIL");
		$finish;
	end

	// Receiver: random stalls at recv_stall_pct, plus a long forced hold
	// on request, counted down here.
	always @(posedge clk) begin
		if (hold_request != 0) begin
			hold_left    = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			dout_if.ready <= 1'b0;
		end else begin
			dout_if.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// ---------------------------------------------------------------
	// Sender side
	// ---------------------------------------------------------------
	// One input beat; returns at the edge that accepts it, valid still high.
	task automatic push_byte(input logic [BYTE_W-1:0] b, input logic first,
			input logic last, input logic [FRAME_NUM_W-1:0] fnum);
		while ($urandom_range(99) < send_idle_pct) begin
			din_if.valid <= 1'b0;
			@(posedge clk);
		end
		din_if.valid         <= 1'b1;
		din_if.in_byte       <= b;
		din_if.first_of_nal  <= first;
		din_if.last_of_nal   <= last;
		din_if.new_frame_num <= fnum;
		do @(posedge clk); while (!din_if.ready);
		items_sent++;
	endtask

	// Stop sending and wait until every owed beat is out, then let a
	// trailing dropped 03 clear the pipe.
	task automatic drain_rewriter();
		din_if.valid <= 1'b0;
		@(posedge clk);
		while (rewritten_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_fnum_width(input logic [CFG_W-1:0] v);
		drain_rewriter();
		cfg_if.valid                 <= 1'b1;
		cfg_if.frame_num_bits_minus4 <= v;
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		fn_bits_m4 = v;
	endtask

	// Zero-heavy so escapes and zero runs show up often.
	function automatic logic [7:0] rand_payload_byte();
		int r;
		r = $urandom_range(99);
		if (r < 40) return 8'h00;
		if (r < 55) return 8'($urandom_range(1, 3));
		return 8'($urandom_range(255));
	endfunction

	// One random NAL: mostly well-formed slice headers with random codes,
	// some with an overlong Golomb prefix, some cut short, some pure noise.
	task automatic send_random_nal();
		bit          bits[$];
		logic [7:0]  raw[$];
		logic [7:0]  esc[$];
		logic [7:0]  v;
		logic [15:0] fnum;
		int          kind, bad_code, zeros, r, n, run, w, cut;
		kind = $urandom_range(99);
		r = $urandom_range(7);
		fnum = (r == 0) ? 16'h0000 : (r == 1) ? 16'hffff : 16'($urandom);
		if (kind < 10) begin
			// noise: random flags, header marks anywhere, missing marks
			n = $urandom_range(1, 12);
			repeat (n) push_byte(rand_payload_byte(), $urandom_range(9) == 0,
				$urandom_range(7) == 0, 16'($urandom));
			return;
		end
		bad_code = (kind < 20) ? $urandom_range(0, 2) : 3;
		for (int c = 0; c < 3; c++) begin
			r = $urandom_range(9);
			zeros = (r < 6) ? $urandom_range(0, 2) :
				(r < 9) ? $urandom_range(3, 8) : $urandom_range(9, 31);
			if (c == bad_code) zeros = $urandom_range(32, 40);
			repeat (zeros) bits.push_back(1'b0);
			bits.push_back(1'b1);
			repeat (zeros) bits.push_back(1'($urandom_range(1)));
		end
		// frame number field: usually the configured width, sometimes not
		w = ($urandom_range(3) == 0) ? $urandom_range(4, 16) : field_width();
		repeat (w) bits.push_back(1'($urandom_range(1)));
		n = $urandom_range(0, 6);
		repeat (n) begin
			v = rand_payload_byte();
			for (int i = 7; i >= 0; i--) bits.push_back(v[i]);
		end
		// rbsp stop bit and alignment
		bits.push_back(1'b1);
		while (bits.size() % 8 != 0) bits.push_back(1'b0);
		for (int k = 0; k < bits.size(); k += 8) begin
			for (int j = 0; j < 8; j++) v[7-j] = bits[k+j];
			raw.push_back(v);
		end
		run = 0;
		foreach (raw[i]) begin
			if (run >= 2 && raw[i] <= 8'h03) begin
				esc.push_back(EMU_PREVENT_BYTE);
				run = 0;
			end
			esc.push_back(raw[i]);
			run = (raw[i] == 8'h00) ? run + 1 : 0;
		end
		if (kind >= 20 && kind < 30) begin
			// NAL ends before the header is done (or right at its end)
			cut = $urandom_range(0, esc.size() - 1);
			while (esc.size() > cut) void'(esc.pop_back());
		end
		push_byte(8'($urandom_range(255)), 1'b1, esc.size() == 0, fnum);
		foreach (esc[i]) push_byte(esc[i], 1'b0, i == esc.size() - 1, 16'($urandom));
	endtask

	task automatic send_until(input int unsigned count);
		int unsigned start;
		start = items_sent;
		while (items_sent - start < count) send_random_nal();
	endtask

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------
	task automatic test_directed();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		write_fnum_width(4'd0);
		// header byte that is also the last one
		push_byte(8'h65, 1'b1, 1'b1, 16'hffff);
		// no header mark; 32 prefix zeros abort the parse; 00 00 00 and
		// 00 00 01 are illegal but pass as data and get escaped
		push_byte(8'h41, 1'b0, 1'b0, 16'h0000);
		push_byte(8'h80, 1'b0, 1'b0, 16'h0000);
		push_byte(8'h00, 1'b0, 1'b0, 16'hffff);
		push_byte(8'h00, 1'b0, 1'b0, 16'h0000);
		push_byte(8'h00, 1'b0, 1'b0, 16'h0000);
		push_byte(8'h00, 1'b0, 1'b0, 16'h0000);
		push_byte(8'h01, 1'b0, 1'b0, 16'h0000);
		push_byte(8'hff, 1'b0, 1'b1, 16'h0000);
		// trailing emulation prevention byte closes the NAL
		push_byte(8'h25, 1'b1, 1'b0, 16'h0000);
		push_byte(8'h00, 1'b0, 1'b0, 16'h0000);
		push_byte(8'h00, 1'b0, 1'b0, 16'h0000);
		push_byte(8'h03, 1'b0, 1'b1, 16'h0000);
		// header mark in the middle of a NAL restarts it
		push_byte(8'h21, 1'b1, 1'b0, 16'h1234);
		push_byte(8'hf0, 1'b0, 1'b0, 16'h0000);
		push_byte(8'h01, 1'b1, 1'b0, 16'hffff);
		push_byte(8'hff, 1'b0, 1'b1, 16'h0000);
		// short well-formed header: 1 / 011 / 1, then a 4-bit field
		// straddling the byte boundary, all ones written
		push_byte(8'h41, 1'b1, 1'b0, 16'hffff);
		push_byte(8'hb8, 1'b0, 1'b0, 16'h0000);
		push_byte(8'h00, 1'b0, 1'b1, 16'h0000);
	endtask

	// Field width extremes, saturation above 12, and a random middle value.
	task automatic test_field_widths();
		logic [CFG_W-1:0] widths[5];
		widths = '{4'd0, 4'd12, 4'd15, 4'd13, 4'($urandom_range(1, 11))};
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		foreach (widths[i]) begin
			write_fnum_width(widths[i]);
			send_until(90);
		end
	endtask

	task automatic test_idle_modes();
		int send_pct[4];
		int recv_pct[4];
		send_pct = '{0, 60, 0, 34};
		recv_pct = '{0, 0, 60, 34};
		for (int m = 0; m < 4; m++) begin
			write_fnum_width(4'($urandom_range(15)));
			send_idle_pct  = send_pct[m];
			recv_stall_pct = recv_pct[m];
			send_until(200);
		end
	endtask

	// Receiver holds off long enough for the block to fill and push back
	// on the input while beats keep being offered; then the sender waits
	// for a full drain before carrying on.
	task automatic test_backpressure();
		write_fnum_width(4'($urandom_range(15)));
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_request   = LONG_HOLD;
		send_until(80);
		drain_rewriter();
		send_idle_pct  = 34;
		recv_stall_pct = 34;
		send_until(20);
	endtask

	initial begin
		din_if.valid                 <= 1'b0;
		din_if.in_byte               <= '0;
		din_if.first_of_nal          <= 1'b0;
		din_if.last_of_nal           <= 1'b0;
		din_if.new_frame_num         <= '0;
		cfg_if.valid                 <= 1'b0;
		cfg_if.frame_num_bits_minus4 <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_field_widths();
		test_idle_modes();
		test_backpressure();

		drain_rewriter();
		if (fail_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire

/* files.f */
src/shfnr_pkg.sv
src/shfnr_if.sv
src/slice_header_frame_num_rewriter.sv
test/tb_slice_header_frame_num_rewriter.sv
